// ----- design/ridge_orientation_field_unit_defines.svh -----
// Assertion macros for the ridge orientation field unit
`ifndef RIDGE_ORIENTATION_FIELD_UNIT_DEFINES_SVH
`define RIDGE_ORIENTATION_FIELD_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define ROF_ASSERT_IMP(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("rof assertion failed");

// next-cycle implication
`define ROF_ASSERT_NXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("rof assertion failed");

`endif

// ----- design/rof_pkg.sv -----
// Shared constants and the arctangent table of the ridge orientation field unit
`timescale 1ns / 1ps

package rof_pkg;

  localparam int IMAGE_W_DEF    = 256;
  localparam int IMAGE_H_DEF    = 288;
  localparam int MAX_HALF_DEF   = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int PIXEL_W        = 8;
  localparam int WIN_HALF_W     = 4;
  localparam logic [WIN_HALF_W-1:0] WIN_HALF_RESET = 4'd8;

  localparam int GRAD_W         = 12;
  localparam int PROD_W         = 2 * GRAD_W;
  localparam int CORDIC_W       = 36;
  localparam int Z_W            = 26;
  localparam int CORDIC_STEPS   = 20;
  localparam int NORM_BIT       = 30;
  localparam int HALF_TURN      = 8388608;
  localparam int QUARTER_TURN   = HALF_TURN / 2;
  localparam int ANGLE_BIAS     = 3 * HALF_TURN + 128;
  localparam int ANGLE_W        = 16;
  localparam int ANGLE_LSB      = 8;

  // round(atan(2^-i) * 2^23 / pi)
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 26'sd2097152;
      5'd1:    v = 26'sd1238021;
      5'd2:    v = 26'sd654136;
      5'd3:    v = 26'sd332050;
      5'd4:    v = 26'sd166669;
      5'd5:    v = 26'sd83416;
      5'd6:    v = 26'sd41718;
      5'd7:    v = 26'sd20860;
      5'd8:    v = 26'sd10430;
      5'd9:    v = 26'sd5215;
      5'd10:   v = 26'sd2608;
      5'd11:   v = 26'sd1304;
      5'd12:   v = 26'sd652;
      5'd13:   v = 26'sd326;
      5'd14:   v = 26'sd163;
      5'd15:   v = 26'sd81;
      5'd16:   v = 26'sd41;
      5'd17:   v = 26'sd20;
      5'd18:   v = 26'sd10;
      5'd19:   v = 26'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/rof_front.sv -----
// Front end: config register, raster position, line store writes, center classification
`timescale 1ns / 1ps

module rof_front #(
  parameter int IMAGE_W  = rof_pkg::IMAGE_W_DEF,
  parameter int IMAGE_H  = rof_pkg::IMAGE_H_DEF,
  parameter int MAX_HALF = rof_pkg::MAX_HALF_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rof_pkg::WIN_HALF_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [rof_pkg::PIXEL_W-1:0] pixel,
  input  logic frame_start,
  input  logic hold,
  output logic q_valid,
  input  logic q_ready,
  output logic [2*$clog2(IMAGE_W)+$clog2(IMAGE_H)+$clog2(2*MAX_HALF+1)
                +$clog2(MAX_HALF+1)+1:0] q_data,
  output logic wr_en,
  output logic [$clog2(2*MAX_HALF+1)+$clog2(IMAGE_W)-1:0] wr_addr,
  output logic [rof_pkg::PIXEL_W-1:0] wr_data
);

  localparam int XW    = $clog2(IMAGE_W);
  localparam int YW    = $clog2(IMAGE_H);
  localparam int LINES = 2 * MAX_HALF + 1;
  localparam int LW    = $clog2(LINES);
  localparam int WHW   = $clog2(MAX_HALF + 1);
  localparam int AW    = ((XW > YW) ? XW : YW) + 2;
  localparam int SW    = LW + 1;

  logic [rof_pkg::WIN_HALF_W-1:0] window_half;
  logic [XW-1:0] pos_x;
  logic [YW-1:0] pos_y;
  logic [LW-1:0] pos_slot;

  logic [WHW-1:0] w_eff;
  logic [XW-1:0]  x_cur;
  logic [YW-1:0]  y_cur;
  logic [LW-1:0]  slot_cur;
  logic [AW-1:0]  xe, ye, we, cxe, cye, i0e;
  logic [SW-1:0]  w2, top_slot;
  logic           cv, ir, acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_half <= rof_pkg::WIN_HALF_RESET;
    end else if (cfg_valid) begin
      window_half <= cfg_data;
    end
  end

  always_comb begin
    if (window_half == '0) begin
      w_eff = WHW'(1);
    end else if (int'(window_half) > MAX_HALF) begin
      w_eff = WHW'(MAX_HALF);
    end else begin
      w_eff = WHW'(window_half);
    end
  end

  assign x_cur    = frame_start ? '0 : pos_x;
  assign y_cur    = frame_start ? '0 : pos_y;
  assign slot_cur = frame_start ? '0 : pos_slot;

  always_comb begin
    xe  = AW'(x_cur);
    ye  = AW'(y_cur);
    we  = AW'(w_eff);
    cxe = xe - we;
    cye = ye - we;
    i0e = cxe - we;
    cv  = (xe >= we) && (ye >= we);
    ir  = cv && (cxe >= we + AW'(1)) && (cxe + we + AW'(2) <= AW'(IMAGE_W))
             && (cye >= we + AW'(1)) && (cye + we + AW'(2) <= AW'(IMAGE_H));
    w2  = SW'(w_eff) << 1;
    top_slot = (SW'(slot_cur) >= w2) ? SW'(slot_cur) - w2
                                     : SW'(slot_cur) + SW'(LINES) - w2;
  end

  assign in_ready = q_ready && !hold;
  assign acc      = in_valid && in_ready;
  assign q_valid  = acc;
  assign q_data   = {w_eff, top_slot[LW-1:0], i0e[XW-1:0],
                     cv ? cye[YW-1:0] : YW'(0), cv ? cxe[XW-1:0] : XW'(0), ir, cv};

  assign wr_en   = acc;
  assign wr_addr = {slot_cur, x_cur};
  assign wr_data = pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x    <= '0;
      pos_y    <= '0;
      pos_slot <= '0;
    end else if (acc) begin
      if (x_cur == XW'(IMAGE_W - 1)) begin
        pos_x <= '0;
        if (y_cur == YW'(IMAGE_H - 1)) begin
          pos_y    <= '0;
          pos_slot <= '0;
        end else begin
          pos_y    <= y_cur + YW'(1);
          pos_slot <= (slot_cur == LW'(LINES - 1)) ? '0 : slot_cur + LW'(1);
        end
      end else begin
        pos_x    <= x_cur + XW'(1);
        pos_y    <= y_cur;
        pos_slot <= slot_cur;
      end
    end
  end

endmodule

// ----- design/rof_fifo.sv -----
// Short queue between the front and back ends
`timescale 1ns / 1ps

module rof_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rof_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push, pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- design/rof_back.sv -----
// Back end: line store, windowed gradient moments, CORDIC angle, output register
`timescale 1ns / 1ps

module rof_back #(
  parameter int IMAGE_W  = rof_pkg::IMAGE_W_DEF,
  parameter int IMAGE_H  = rof_pkg::IMAGE_H_DEF,
  parameter int MAX_HALF = rof_pkg::MAX_HALF_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [$clog2(2*MAX_HALF+1)+$clog2(IMAGE_W)-1:0] wr_addr,
  input  logic [rof_pkg::PIXEL_W-1:0] wr_data,
  input  logic q_valid,
  output logic q_ready,
  input  logic [2*$clog2(IMAGE_W)+$clog2(IMAGE_H)+$clog2(2*MAX_HALF+1)
                +$clog2(MAX_HALF+1)+1:0] q_data,
  output logic out_valid,
  input  logic out_ready,
  output logic out_cv,
  output logic out_ir,
  output logic [$clog2(IMAGE_W)-1:0] out_cx,
  output logic [$clog2(IMAGE_H)-1:0] out_cy,
  output logic [rof_pkg::ANGLE_W-1:0] out_angle,
  output logic region_done
);

  localparam int XW     = $clog2(IMAGE_W);
  localparam int YW     = $clog2(IMAGE_H);
  localparam int LINES  = 2 * MAX_HALF + 1;
  localparam int LW     = $clog2(LINES);
  localparam int WHW    = $clog2(MAX_HALF + 1);
  localparam int DW     = WHW + 1;
  localparam int SUM_W  = rof_pkg::PROD_W + $clog2((2*MAX_HALF-1) * (2*MAX_HALF-1));
  localparam int MEM_DEPTH = LINES << XW;
  localparam int CW     = rof_pkg::CORDIC_W;
  localparam int ZW     = rof_pkg::Z_W;
  localparam int GW     = rof_pkg::GRAD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_GRAD  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_CLASS = 4'd7;
  localparam logic [3:0] S_NORM  = 4'd8;
  localparam logic [3:0] S_ROT   = 4'd9;
  localparam logic [3:0] S_CORD  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  function automatic logic signed [GW-1:0] ext(input logic [rof_pkg::PIXEL_W-1:0] v);
    return $signed({{(GW - rof_pkg::PIXEL_W){1'b0}}, v});
  endfunction

  logic [rof_pkg::PIXEL_W-1:0] mem [MEM_DEPTH];
  logic [rof_pkg::PIXEL_W-1:0] mem_q;
  logic [LW+XW-1:0] rd_addr;
  logic rd_en;

  logic [3:0] state;
  logic [XW-1:0] it_cx, it_i0, col_i;
  logic [YW-1:0] it_cy;
  logic [LW-1:0] slot_j;
  logic [WHW-1:0] it_w;
  logic [DW-1:0] di, dj, lim;
  logic [1:0] ra, rb, ra_d, rb_d;
  logic rd_v;
  logic [rof_pkg::PIXEL_W-1:0] nb [3][3];
  logic signed [GW-1:0] bx, by;
  logic signed [rof_pkg::PROD_W-1:0] pxx, pyy, pxy;
  logic signed [SUM_W-1:0] sxx, syy, sxy;
  logic signed [CW-1:0] x, y, ax, ay, dx, dy;
  logic signed [ZW-1:0] z;
  logic [4:0] ci;
  logic [rof_pkg::ANGLE_W-1:0] res_angle;
  logic signed [ZW:0] ang_sum;

  logic q_cv, q_ir, out_free, load_idle, load_done;
  logic [XW-1:0] q_cx, q_i0;
  logic [YW-1:0] q_cy;
  logic [LW-1:0] q_top;
  logic [WHW-1:0] q_w;
  logic [LW:0] slot_sum;
  logic [LW-1:0] slot_b;

  assign {q_w, q_top, q_i0, q_cy, q_cx, q_ir, q_cv} = q_data;

  assign out_free  = !out_valid || out_ready;
  assign q_ready   = (state == S_IDLE) && (q_ir || out_free);
  assign load_idle = (state == S_IDLE) && q_valid && !q_ir && out_free;
  assign load_done = (state == S_DONE) && out_free;
  assign region_done = load_done;

  assign lim = {it_w, 1'b0} - DW'(2);

  always_comb begin
    slot_sum = {1'b0, slot_j} + (LW + 1)'(rb);
    slot_b   = (slot_sum >= (LW + 1)'(LINES)) ? LW'(slot_sum - (LW + 1)'(LINES))
                                              : slot_sum[LW-1:0];
    rd_addr  = {slot_b, col_i + XW'(ra)};
    rd_en    = (state == S_READ);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= rd_en;
    end
    ra_d <= ra;
    rb_d <= rb;
    if (rd_v) begin
      nb[rb_d][ra_d] <= mem_q;
    end
  end

  assign dx = y >>> ci;
  assign dy = x >>> ci;
  assign ang_sum = (ZW + 1)'(rof_pkg::ANGLE_BIAS) - (ZW + 1)'(z);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && q_ir) begin
            it_cx  <= q_cx;
            it_cy  <= q_cy;
            it_i0  <= q_i0;
            it_w   <= q_w;
            col_i  <= q_i0;
            slot_j <= q_top;
            di     <= '0;
            dj     <= '0;
            ra     <= '0;
            rb     <= '0;
            sxx    <= '0;
            syy    <= '0;
            sxy    <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          if (ra == 2'd2) begin
            ra <= '0;
            if (rb == 2'd2) begin
              rb    <= '0;
              state <= S_LAST;
            end else begin
              rb <= rb + 2'd1;
            end
          end else begin
            ra <= ra + 2'd1;
          end
        end
        S_LAST: begin
          state <= S_GRAD;
        end
        S_GRAD: begin
          bx <= ext(nb[0][2]) + (ext(nb[1][2]) <<< 1) + ext(nb[2][2])
              - ext(nb[0][0]) - (ext(nb[1][0]) <<< 1) - ext(nb[2][0]);
          by <= ext(nb[2][0]) + (ext(nb[2][1]) <<< 1) + ext(nb[2][2])
              - ext(nb[0][0]) - (ext(nb[0][1]) <<< 1) - ext(nb[0][2]);
          state <= S_MUL;
        end
        S_MUL: begin
          pxx   <= bx * bx;
          pyy   <= by * by;
          pxy   <= bx * by;
          state <= S_ACC;
        end
        S_ACC: begin
          sxx <= sxx + SUM_W'(pxx);
          syy <= syy + SUM_W'(pyy);
          sxy <= sxy + SUM_W'(pxy);
          if (di == lim) begin
            di    <= '0;
            col_i <= it_i0;
            if (dj == lim) begin
              state <= S_DIFF;
            end else begin
              dj     <= dj + DW'(1);
              slot_j <= (slot_j == LW'(LINES - 1)) ? '0 : slot_j + LW'(1);
              state  <= S_READ;
            end
          end else begin
            di    <= di + DW'(1);
            col_i <= col_i + XW'(1);
            state <= S_READ;
          end
        end
        S_DIFF: begin
          x     <= CW'(sxx) - CW'(syy);
          y     <= CW'(sxy) <<< 1;
          state <= S_CLASS;
        end
        S_CLASS: begin
          if (y == '0) begin
            z     <= x[CW-1] ? ZW'(rof_pkg::HALF_TURN) : '0;
            state <= S_FIN;
          end else if (x == '0) begin
            z     <= y[CW-1] ? -ZW'(rof_pkg::QUARTER_TURN) : ZW'(rof_pkg::QUARTER_TURN);
            state <= S_FIN;
          end else begin
            ax    <= x[CW-1] ? -x : x;
            ay    <= y[CW-1] ? -y : y;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (ax[CW-1:rof_pkg::NORM_BIT] == '0 && ay[CW-1:rof_pkg::NORM_BIT] == '0) begin
            x  <= x <<< 1;
            y  <= y <<< 1;
            ax <= ax <<< 1;
            ay <= ay <<< 1;
          end else begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (x[CW-1]) begin
            if (!y[CW-1]) begin
              x <= y;
              y <= -x;
              z <= ZW'(rof_pkg::QUARTER_TURN);
            end else begin
              x <= -y;
              y <= x;
              z <= -ZW'(rof_pkg::QUARTER_TURN);
            end
          end else begin
            z <= '0;
          end
          ci    <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (!y[CW-1]) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + rof_pkg::atan_entry(ci);
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - rof_pkg::atan_entry(ci);
          end
          if (ci == 5'(rof_pkg::CORDIC_STEPS - 1)) begin
            state <= S_FIN;
          end else begin
            ci <= ci + 5'd1;
          end
        end
        S_FIN: begin
          res_angle <= ang_sum[rof_pkg::ANGLE_LSB+rof_pkg::ANGLE_W-1:rof_pkg::ANGLE_LSB];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_idle || load_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_idle) begin
      out_cv    <= q_cv;
      out_ir    <= 1'b0;
      out_cx    <= q_cx;
      out_cy    <= q_cy;
      out_angle <= '0;
    end else if (load_done) begin
      out_cv    <= 1'b1;
      out_ir    <= 1'b1;
      out_cx    <= it_cx;
      out_cy    <= it_cy;
      out_angle <= res_angle;
    end
  end

endmodule

// ----- design/ridge_orientation_field_unit.sv -----
// Top level of the ridge orientation field unit
`timescale 1ns / 1ps
`include "ridge_orientation_field_unit_defines.svh"

// Pixels enter in raster order and each gives one result for the center
// (x-w, y-w). A pixel whose center lies on the border or before the image
// start passes without holding the input. A center inside the border
// holds the input until its angle is done: the back end reads each 3x3
// neighborhood from the line store one pixel a cycle, sums the gradient
// moments over (2w-1)^2 window positions, then shifts to normalize and
// runs 20 CORDIC steps. The line store needs no clearing pass after reset.
module ridge_orientation_field_unit #(
  parameter int IMAGE_W  = rof_pkg::IMAGE_W_DEF,
  parameter int IMAGE_H  = rof_pkg::IMAGE_H_DEF,
  parameter int MAX_HALF = rof_pkg::MAX_HALF_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rof_pkg::WIN_HALF_W-1:0] cfg_data,   // window_half
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [rof_pkg::PIXEL_W-1:0] s_axis_tdata,  // pixel
  input  logic [0:0] s_axis_tuser,                   // frame_start
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // center_x, center_y, angle, zero fill
  output logic [(($clog2(IMAGE_W)+$clog2(IMAGE_H)+rof_pkg::ANGLE_W+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0] m_axis_tuser                    // center_valid, in_region
);

  localparam int XW     = $clog2(IMAGE_W);
  localparam int YW     = $clog2(IMAGE_H);
  localparam int LW     = $clog2(2 * MAX_HALF + 1);
  localparam int WHW    = $clog2(MAX_HALF + 1);
  localparam int ITEM_W = 2 * XW + YW + LW + WHW + 2;
  localparam int OUT_DW = ((XW + YW + rof_pkg::ANGLE_W + 7) / 8) * 8;

  logic push, push_ready, pop_valid, pop_ready, region_busy, region_done;
  logic [ITEM_W-1:0] push_data, pop_data;
  logic wr_en;
  logic [LW+XW-1:0] wr_addr;
  logic [rof_pkg::PIXEL_W-1:0] wr_data;
  logic out_cv, out_ir;
  logic [XW-1:0] out_cx;
  logic [YW-1:0] out_cy;
  logic [rof_pkg::ANGLE_W-1:0] out_angle;

  rof_front #(
    .IMAGE_W(IMAGE_W), .IMAGE_H(IMAGE_H), .MAX_HALF(MAX_HALF)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .pixel(s_axis_tdata), .frame_start(s_axis_tuser[0]),
    .hold(region_busy),
    .q_valid(push), .q_ready(push_ready), .q_data(push_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  rof_fifo #(
    .WIDTH(ITEM_W), .DEPTH(rof_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(push), .wr_ready(push_ready), .wr_data(push_data),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_data)
  );

  rof_back #(
    .IMAGE_W(IMAGE_W), .IMAGE_H(IMAGE_H), .MAX_HALF(MAX_HALF)
  ) u_back (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .q_valid(pop_valid), .q_ready(pop_ready), .q_data(pop_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_cv(out_cv), .out_ir(out_ir), .out_cx(out_cx), .out_cy(out_cy),
    .out_angle(out_angle), .region_done(region_done)
  );

  // the line store must not move on while a window is being summed
  always_ff @(posedge clk) begin
    if (rst) begin
      region_busy <= 1'b0;
    end else if (push && push_data[1]) begin
      region_busy <= 1'b1;
    end else if (region_done) begin
      region_busy <= 1'b0;
    end
  end

  assign m_axis_tdata = OUT_DW'({out_angle, out_cy, out_cx});
  assign m_axis_tuser = {out_ir, out_cv};

  `ROF_ASSERT_IMP(a_no_accept_while_busy, s_axis_tready, !region_busy)
  `ROF_ASSERT_NXT(a_busy_after_region_push, push && push_data[1], region_busy)
  `ROF_ASSERT_IMP(a_region_has_center, m_axis_tvalid && out_ir, out_cv)
  `ROF_ASSERT_IMP(a_border_angle_zero, m_axis_tvalid && !out_ir, out_angle == '0)

endmodule
